### design/cdo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdo_pkg: calendar date day offset shared definitions
// Result status codes, calendar constants, reciprocal constants for the
// fixed divisors and the month tables.
// ----------------------------------------------------------------------------
package cdo_pkg;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_BAD_DATE     = 2'd1,
		ST_OUT_OF_RANGE = 2'd2
	} status_t;

	localparam logic [3:0]  MON_JAN = 4'd1;
	localparam logic [3:0]  MON_FEB = 4'd2;
	localparam logic [3:0]  MON_DEC = 4'd12;

	localparam logic [13:0] YEAR_BASE   = 14'd1901;
	// first year of the 400-year cycle the back conversion counts from
	localparam logic [13:0] CYCLE_BASE  = 14'd1601;
	// leap years in 1..1900
	localparam logic [11:0] LEAPS_1900  = 12'd460;
	// day number minus one plus the days from 1 Jan 1601 to 1 Jan 1901
	localparam logic [21:0] EPOCH_SHIFT = 22'd109571;

	localparam int DAYS_400Y = 146097;
	localparam int DAYS_100Y = 36524;
	localparam int DAYS_4Y   = 1461;
	localparam int DAYS_1Y   = 365;

	// ceil(2^k / d), exact for the operand ranges used
	localparam logic [12:0] RECIP_100  = 13'(((64'd1 << 19) + 64'd99) / 64'd100);
	localparam logic [22:0] RECIP_400Y = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
	localparam logic [16:0] RECIP_4Y   = 17'(((64'd1 << 27) + 64'd1460) / 64'd1461);
	localparam logic [22:0] RECIP_7    = 23'(((64'd1 << 25) + 64'd6) / 64'd7);

	// length of a month in a common year, 0 for a code that is no month
	function automatic logic [4:0] month_len_f(input logic [3:0] mon);
		logic [4:0] len;
		len = 5'd0;
		if (mon inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
			len = 5'd30;
		end else if (mon == MON_FEB) begin
			len = 5'd28;
		end else if (mon >= MON_JAN && mon <= MON_DEC) begin
			len = 5'd31;
		end
		return len;
	endfunction

	// days of a common year before the first of the month
	function automatic logic [8:0] cum_days_f(input logic [3:0] mon);
		logic [8:0] cum;
		case (mon)
			4'd1:    cum = 9'd0;
			4'd2:    cum = 9'd31;
			4'd3:    cum = 9'd59;
			4'd4:    cum = 9'd90;
			4'd5:    cum = 9'd120;
			4'd6:    cum = 9'd151;
			4'd7:    cum = 9'd181;
			4'd8:    cum = 9'd212;
			4'd9:    cum = 9'd243;
			4'd10:   cum = 9'd273;
			4'd11:   cum = 9'd304;
			4'd12:   cum = 9'd334;
			default: cum = 9'd0;
		endcase
		return cum;
	endfunction

endpackage
`default_nettype wire

### design/calendar_date_day_offset.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_date_day_offset: Gregorian date plus signed day offset
// Converts a date to a day number (1 Jan 1901 is day 1), adds the offset,
// converts back and reports the new date, day number and weekday.
//
//   channel  dir  beat contents
//   s_axis   in   tdata: day_in, month_in, year_in, day_offset
//   m_axis   out  tdata: day_out, month_out, year_out, day_count, weekday
//                 tuser: status
//
// One beat per cycle sustained while m_axis is ready. The pipeline depth is
// set by the chain of reciprocal multiplies that split the day number into
// 400-year, century, 4-year and year parts. Reset clears only the stage
// valid bits. Each stage moves up when the next one is empty or moving, so
// bubbles close up under a stalled m_axis and s_axis keeps taking beats
// until all twelve stages are full.
// ----------------------------------------------------------------------------
module calendar_date_day_offset
	import cdo_pkg::*;
#(
	parameter int MAX_YEAR = 9999
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	// day_in[4:0], month_in[8:5], year_in[22:9], day_offset[45:23], zero[47:46]
	input  wire logic [47:0] s_axis_tdata,
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// day_out[4:0], month_out[8:5], year_out[22:9], day_count[44:23],
	// weekday[47:45]
	output      logic [47:0] m_axis_tdata,
	// status[1:0]
	output      logic [1:0]  m_axis_tuser
);

	localparam int NSTAGE = 12;
	// last valid day number: days up to 31 Dec MAX_YEAR
	localparam int LIMIT = 365 * (MAX_YEAR - 1900) + MAX_YEAR / 4 - MAX_YEAR / 100
		+ MAX_YEAR / 400 - 460;
	localparam logic signed [23:0] N_LIMIT = 24'(LIMIT);
	localparam logic [13:0] YEAR_MAX = 14'(MAX_YEAR);

	// stage valid bits and load enables
	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] load;

	always_comb begin
		load[NSTAGE] = !vld_q[NSTAGE] || m_axis_tready;
		for (int i = NSTAGE - 1; i >= 1; i--) begin
			load[i] = !vld_q[i] || load[i + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (load[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int i = 2; i <= NSTAGE; i++) begin
				if (load[i]) begin
					vld_q[i] <= vld_q[i - 1];
				end
			end
		end
	end

	assign s_axis_tready = load[1];
	assign m_axis_tvalid = vld_q[NSTAGE];

	// ---------------------------------------------------------------- s1
	logic [4:0]         day_s1;
	logic [3:0]         month_s1;
	logic [13:0]        year_s1;
	logic signed [22:0] off_s1;

	// ---------------------------------------------------------------- s1 -> s2
	logic [26:0] cent_prod;
	logic [13:0] yrel;
	logic [21:0] y365_c;

	assign cent_prod = 27'(year_s1) * 27'(RECIP_100);
	assign yrel      = year_s1 - YEAR_BASE;
	assign y365_c    = 22'(yrel) * 22'(DAYS_1Y);

	logic [4:0]         day_s2;
	logic [3:0]         month_s2;
	logic [13:0]        year_s2;
	logic signed [22:0] off_s2;
	logic [7:0]         cent_s2;
	logic [21:0]        y365_s2;

	// ---------------------------------------------------------------- s2 -> s3
	logic [13:0] rem100;
	logic        century;
	logic        leap_in;
	logic [7:0]  cent_m1;
	logic [13:0] ym1;
	logic [11:0] leaps_c;
	logic [4:0]  mlen_c;
	logic        bad_c;
	logic [8:0]  doy0_c;

	always_comb begin
		rem100  = year_s2 - 14'(cent_s2) * 14'd100;
		century = (rem100 == 14'd0);
		leap_in = (year_s2[1:0] == 2'b00) && (!century || cent_s2[1:0] == 2'b00);
		// centuries up to year - 1
		cent_m1 = cent_s2 - 8'(century);
		ym1     = year_s2 - 14'd1;
		leaps_c = 12'(ym1 >> 2) - 12'(cent_m1) + 12'(cent_m1 >> 2) - LEAPS_1900;
		mlen_c  = (month_s2 == MON_FEB && leap_in) ? 5'd29 : month_len_f(month_s2);
		bad_c   = (month_s2 < MON_JAN) || (month_s2 > MON_DEC) || (year_s2 < YEAR_BASE)
			|| (year_s2 > YEAR_MAX) || (day_s2 == 5'd0) || (day_s2 > mlen_c);
		doy0_c  = cum_days_f(month_s2) + 9'(leap_in && month_s2 > MON_FEB) + 9'(day_s2);
	end

	logic               bad_s3;
	logic [11:0]        leaps_s3;
	logic [8:0]         doy0_s3;
	logic [21:0]        y365_s3;
	logic signed [22:0] off_s3;

	// ---------------------------------------------------------------- s3 -> s4
	logic [21:0] base_c;

	assign base_c = y365_s3 + 22'(leaps_s3) + 22'(doy0_s3);

	logic               bad_s4;
	logic [21:0]        base_s4;
	logic signed [22:0] off_s4;

	// ---------------------------------------------------------------- s4 -> s5
	logic signed [23:0] n_c;
	status_t            status_c;

	always_comb begin
		n_c = $signed({2'b00, base_s4}) + $signed({off_s4[22], off_s4});
		if (bad_s4) begin
			status_c = ST_BAD_DATE;
		end else if (n_c <= 24'sd0 || n_c > N_LIMIT) begin
			status_c = ST_OUT_OF_RANGE;
		end else begin
			status_c = ST_OK;
		end
	end

	status_t     status_s5;
	logic [21:0] n_s5;
	logic [21:0] z_s5;
	logic [21:0] n1_s5;

	// ---------------------------------------------------------------- s5 -> s6
	logic [44:0] p400;
	logic [44:0] p7;

	assign p400 = 45'(z_s5) * 45'(RECIP_400Y);
	assign p7   = 45'(n1_s5) * 45'(RECIP_7);

	status_t     status_s6;
	logic [21:0] n_s6;
	logic [21:0] z_s6;
	logic [21:0] n1_s6;
	logic [4:0]  q400_s6;
	logic [18:0] q7_s6;

	// ---------------------------------------------------------------- s6 -> s7
	logic [21:0] r400_full;
	logic [21:0] wd_full;
	logic [13:0] yr6_c;

	always_comb begin
		r400_full = z_s6 - 22'(q400_s6) * 22'(DAYS_400Y);
		wd_full   = n1_s6 - 22'(q7_s6) * 22'd7;
		yr6_c     = CYCLE_BASE + 14'(q400_s6) * 14'd400;
	end

	status_t     status_s7;
	logic [21:0] n_s7;
	logic [2:0]  wday_s7;
	logic [17:0] r400_s7;
	logic [13:0] yr_s7;

	// ---------------------------------------------------------------- s7 -> s8
	// century within the cycle; the last day of the cycle stays in century 3
	logic [1:0]  c_c;
	logic [17:0] r100_full;

	always_comb begin
		c_c = 2'(r400_s7 >= 18'(DAYS_100Y)) + 2'(r400_s7 >= 18'(2 * DAYS_100Y))
			+ 2'(r400_s7 >= 18'(3 * DAYS_100Y));
		r100_full = r400_s7 - 18'(c_c) * 18'(DAYS_100Y);
	end

	status_t     status_s8;
	logic [21:0] n_s8;
	logic [2:0]  wday_s8;
	logic [15:0] r2_s8;
	logic [13:0] yr_s8;
	logic [1:0]  c_s8;

	// ---------------------------------------------------------------- s8 -> s9
	logic [32:0] p4y;

	assign p4y = 33'(r2_s8) * 33'(RECIP_4Y);

	status_t     status_s9;
	logic [21:0] n_s9;
	logic [2:0]  wday_s9;
	logic [15:0] r2_s9;
	logic [13:0] yr_s9;
	logic [1:0]  c_s9;
	logic [4:0]  q4_s9;

	// ---------------------------------------------------------------- s9 -> s10
	logic [15:0] r4_full;

	assign r4_full = r2_s9 - 16'(q4_s9) * 16'(DAYS_4Y);

	status_t     status_s10;
	logic [21:0] n_s10;
	logic [2:0]  wday_s10;
	logic [10:0] r3_s10;
	logic [13:0] yr_s10;
	logic [1:0]  c_s10;
	logic [4:0]  q4_s10;

	// ---------------------------------------------------------------- s10 -> s11
	logic [1:0]  q1_c;
	logic [10:0] doy_full;
	logic        leap_out;

	always_comb begin
		q1_c = 2'(r3_s10 >= 11'(DAYS_1Y)) + 2'(r3_s10 >= 11'(2 * DAYS_1Y))
			+ 2'(r3_s10 >= 11'(3 * DAYS_1Y));
		doy_full = r3_s10 - 11'(q1_c) * 11'(DAYS_1Y);
		// fourth year of a group leaps, bar the century years other than 2000 mod 400
		leap_out = (q1_c == 2'd3) && (q4_s10 != 5'd24 || c_s10 == 2'd3);
	end

	status_t     status_s11;
	logic [21:0] n_s11;
	logic [2:0]  wday_s11;
	logic [8:0]  doy_s11;
	logic [13:0] yr_s11;
	logic        leap_s11;

	// ---------------------------------------------------------------- s11 -> s12
	logic [3:0] mon_c;
	logic [8:0] cum_c;
	logic [4:0] dom_c;

	always_comb begin
		mon_c = MON_JAN;
		for (int m = 2; m <= 12; m++) begin
			if (doy_s11 >= cum_days_f(4'(m)) + 9'(leap_s11 && m > 2)) begin
				mon_c = mon_c + 4'd1;
			end
		end
		cum_c = cum_days_f(mon_c) + 9'(leap_s11 && mon_c > MON_FEB);
		dom_c = 5'(doy_s11 - cum_c) + 5'd1;
	end

	status_t     status_s12;
	logic [4:0]  day_s12;
	logic [3:0]  month_s12;
	logic [13:0] year_s12;
	logic [21:0] count_s12;
	logic [2:0]  wday_s12;

	// ---------------------------------------------------------------- payload
	always_ff @(posedge clk) begin
		if (load[1]) begin
			day_s1   <= s_axis_tdata[4:0];
			month_s1 <= s_axis_tdata[8:5];
			year_s1  <= s_axis_tdata[22:9];
			off_s1   <= $signed(s_axis_tdata[45:23]);
		end
		if (load[2]) begin
			day_s2   <= day_s1;
			month_s2 <= month_s1;
			year_s2  <= year_s1;
			off_s2   <= off_s1;
			cent_s2  <= cent_prod[26:19];
			y365_s2  <= y365_c;
		end
		if (load[3]) begin
			bad_s3   <= bad_c;
			leaps_s3 <= leaps_c;
			doy0_s3  <= doy0_c;
			y365_s3  <= y365_s2;
			off_s3   <= off_s2;
		end
		if (load[4]) begin
			bad_s4  <= bad_s3;
			base_s4 <= base_c;
			off_s4  <= off_s3;
		end
		if (load[5]) begin
			status_s5 <= status_c;
			n_s5      <= n_c[21:0];
			z_s5      <= n_c[21:0] + EPOCH_SHIFT;
			n1_s5     <= n_c[21:0] + 22'd1;
		end
		if (load[6]) begin
			status_s6 <= status_s5;
			n_s6      <= n_s5;
			z_s6      <= z_s5;
			n1_s6     <= n1_s5;
			q400_s6   <= p400[44:40];
			q7_s6     <= p7[43:25];
		end
		if (load[7]) begin
			status_s7 <= status_s6;
			n_s7      <= n_s6;
			wday_s7   <= wd_full[2:0] + 3'd1;
			r400_s7   <= r400_full[17:0];
			yr_s7     <= yr6_c;
		end
		if (load[8]) begin
			status_s8 <= status_s7;
			n_s8      <= n_s7;
			wday_s8   <= wday_s7;
			r2_s8     <= r100_full[15:0];
			yr_s8     <= yr_s7 + 14'(c_c) * 14'd100;
			c_s8      <= c_c;
		end
		if (load[9]) begin
			status_s9 <= status_s8;
			n_s9      <= n_s8;
			wday_s9   <= wday_s8;
			r2_s9     <= r2_s8;
			yr_s9     <= yr_s8;
			c_s9      <= c_s8;
			q4_s9     <= p4y[31:27];
		end
		if (load[10]) begin
			status_s10 <= status_s9;
			n_s10      <= n_s9;
			wday_s10   <= wday_s9;
			r3_s10     <= r4_full[10:0];
			yr_s10     <= yr_s9 + 14'(q4_s9) * 14'd4;
			c_s10      <= c_s9;
			q4_s10     <= q4_s9;
		end
		if (load[11]) begin
			status_s11 <= status_s10;
			n_s11      <= n_s10;
			wday_s11   <= wday_s10;
			doy_s11    <= doy_full[8:0];
			yr_s11     <= yr_s10 + 14'(q1_c);
			leap_s11   <= leap_out;
		end
		if (load[12]) begin
			status_s12 <= status_s11;
			if (status_s11 == ST_OK) begin
				day_s12   <= dom_c;
				month_s12 <= mon_c;
				year_s12  <= yr_s11;
				count_s12 <= n_s11;
				wday_s12  <= wday_s11;
			end else begin
				day_s12   <= '0;
				month_s12 <= '0;
				year_s12  <= '0;
				count_s12 <= '0;
				wday_s12  <= '0;
			end
		end
	end

	assign m_axis_tdata = {wday_s12, count_s12, year_s12, month_s12, day_s12};
	assign m_axis_tuser = status_s12;

	// ---------------------------------------------------------------- checks
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
		else $error("error beat carries non-zero data");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == ST_OK |->
			m_axis_tdata[8:5] >= MON_JAN && m_axis_tdata[8:5] <= MON_DEC
			&& m_axis_tdata[4:0] != 5'd0 && m_axis_tdata[47:45] != 3'd0
			&& m_axis_tdata[44:23] != 22'd0)
		else $error("good beat with an impossible date");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with the output stage empty");

endmodule
`default_nettype wire
